@@ design/bbt_pkg.sv @@
package bbt_pkg;

    // width of the string length limit and of the payload countdown
    localparam int STRING_LENGTH_BITS = 31;
    // width of the string_length result field
    localparam int LEN_OUT_W = 31;
    // integer accumulator width
    localparam int ACC_W = 64;
    // a length below the limit times ten plus a digit fits here
    localparam int STR_ACC_W = STRING_LENGTH_BITS + 4;

    localparam logic [STRING_LENGTH_BITS-1:0] LIMIT_RESET =
        STRING_LENGTH_BITS'(64'd2147483647);

    // largest magnitude that may still take one more digit
    localparam logic [ACC_W-1:0] MAG_TENTH = 64'd922337203685477580;
    localparam logic [3:0] MAX_LAST_DIGIT = 4'd7;

    // decoupling queue, depth a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // characters of the encoding
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DICT  = 8'h64;
    localparam logic [7:0] CH_LIST  = 8'h6C;
    localparam logic [7:0] CH_END   = 8'h65;
    localparam logic [7:0] CH_INT   = 8'h69;

    typedef enum logic [2:0] {
        CLS_DICT,
        CLS_LIST,
        CLS_END,
        CLS_INT,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_COLON,
        CLS_OTHER
    } cls_t;

    // classified byte handed from front to back
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic [7:0] data;
        logic       last;
    } word_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INT_START,
        PH_INT_DIGITS,
        PH_STR_LEN,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DICT   = 3'd0,
        KIND_LIST   = 3'd1,
        KIND_END    = 3'd2,
        KIND_INT    = 3'd3,
        KIND_HEADER = 3'd4,
        KIND_BYTE   = 3'd5,
        KIND_ERROR  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LEAD      = 3'd1,
        ERR_COLON     = 3'd2,
        ERR_INT_END   = 3'd3,
        ERR_TOO_LONG  = 3'd4,
        ERR_TRUNCATED = 3'd5
    } err_t;

endpackage

@@ design/bbt_front.sv @@
module bbt_front (
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    output logic           push_valid,
    input  logic           push_ready,
    output bbt_pkg::word_t push_word
);
    import bbt_pkg::*;

    logic is_digit;

    // handshake straight onto the queue
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // byte classification
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

    always_comb
    begin
        push_word.data  = data_byte;
        push_word.last  = last_byte;
        push_word.digit = 4'(data_byte - CH_ZERO);
        if (is_digit)
        begin
            push_word.cls = CLS_DIGIT;
        end
        else
        begin
            case (data_byte)
                CH_DICT:  push_word.cls = CLS_DICT;
                CH_LIST:  push_word.cls = CLS_LIST;
                CH_END:   push_word.cls = CLS_END;
                CH_INT:   push_word.cls = CLS_INT;
                CH_MINUS: push_word.cls = CLS_MINUS;
                CH_COLON: push_word.cls = CLS_COLON;
                default:  push_word.cls = CLS_OTHER;
            endcase
        end
    end

endmodule

@@ design/bbt_queue.sv @@
module bbt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  bbt_pkg::word_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output bbt_pkg::word_t pop_word
);
    import bbt_pkg::*;

    word_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ design/bbt_back.sv @@
module bbt_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bbt_pkg::STRING_LENGTH_BITS-1:0] cfg_data,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  bbt_pkg::word_t                         pop_word,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             kind,
    output logic signed [63:0]                     int_value,
    output logic [bbt_pkg::LEN_OUT_W-1:0]          str_len,
    output logic [7:0]                             payload_byte,
    output logic [2:0]                             error_code
);
    import bbt_pkg::*;

    logic [STRING_LENGTH_BITS-1:0] limit_reg;
    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic [ACC_W-1:0]              acc_reg;
    logic [ACC_W-1:0]              acc_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic                          ovf_reg;
    logic                          ovf_next;
    logic [STRING_LENGTH_BITS-1:0] rem_reg;
    logic [STRING_LENGTH_BITS-1:0] rem_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    kind_t                         kind_reg;
    logic [ACC_W-1:0]              int_reg;
    logic [LEN_OUT_W-1:0]          len_reg;
    logic [7:0]                    pb_reg;
    err_t                          err_reg;

    logic                          take;
    logic                          emit;
    kind_t                         res_kind;
    logic [ACC_W-1:0]              res_int;
    logic [LEN_OUT_W-1:0]          res_len;
    logic [7:0]                    res_pb;
    err_t                          res_err;
    logic                          fail;
    err_t                          fail_code;

    logic [ACC_W-1:0]              limit_ext;
    logic [ACC_W-1:0]              digit_ext;
    logic [ACC_W-1:0]              int_acc10;
    logic                          int_ovf;
    logic [ACC_W-1:0]              int_mag;
    logic [STR_ACC_W-1:0]          str_acc;
    logic [STR_ACC_W-1:0]          str_acc10;
    logic [STRING_LENGTH_BITS-1:0] rem_dec;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // one queue word per cycle while the output register can take a result
    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;

    // datapath helpers
    assign limit_ext = ACC_W'(limit_reg);
    assign digit_ext = ACC_W'(pop_word.digit);
    assign int_acc10 = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
    assign int_ovf   = (acc_reg > MAG_TENTH) ||
                       ((acc_reg == MAG_TENTH) && (pop_word.digit > MAX_LAST_DIGIT));
    assign int_mag   = ovf_reg ? '0 : acc_reg;
    assign str_acc   = acc_reg[STR_ACC_W-1:0];
    assign str_acc10 = (str_acc << 3) + (str_acc << 1) + STR_ACC_W'(pop_word.digit);
    assign rem_dec   = rem_reg - 1'b1;

    // token state machine
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        emit       = 1'b0;
        res_kind   = KIND_DICT;
        res_int    = '0;
        res_len    = '0;
        res_pb     = '0;
        res_err    = ERR_NONE;
        fail       = 1'b0;
        fail_code  = ERR_NONE;

        if (take)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    acc_next = '0;
                    neg_next = 1'b0;
                    ovf_next = 1'b0;
                    rem_next = '0;
                    case (pop_word.cls)
                        CLS_DICT:
                        begin
                            emit     = 1'b1;
                            res_kind = KIND_DICT;
                        end
                        CLS_LIST:
                        begin
                            emit     = 1'b1;
                            res_kind = KIND_LIST;
                        end
                        CLS_END:
                        begin
                            emit     = 1'b1;
                            res_kind = KIND_END;
                        end
                        CLS_INT:
                        begin
                            if (pop_word.last)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_TRUNCATED;
                            end
                            else
                            begin
                                phase_next = PH_INT_START;
                            end
                        end
                        CLS_DIGIT:
                        begin
                            if (pop_word.last)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_TRUNCATED;
                            end
                            else
                            begin
                                acc_next   = digit_ext;
                                ovf_next   = (digit_ext >= limit_ext);
                                phase_next = PH_STR_LEN;
                            end
                        end
                        default:
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_LEAD;
                        end
                    endcase
                end

                PH_INT_START, PH_INT_DIGITS:
                begin
                    if (pop_word.cls == CLS_END)
                    begin
                        emit       = 1'b1;
                        res_kind   = KIND_INT;
                        res_int    = neg_reg ? (~int_mag + 1'b1) : int_mag;
                        phase_next = PH_IDLE;
                    end
                    else if ((phase_reg == PH_INT_START) && (pop_word.cls == CLS_MINUS))
                    begin
                        if (pop_word.last)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_INT_DIGITS;
                        end
                    end
                    else if (pop_word.cls != CLS_DIGIT)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_INT_END;
                    end
                    else if (pop_word.last)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        if (!ovf_reg)
                        begin
                            if (int_ovf)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                acc_next = int_acc10;
                            end
                        end
                        phase_next = PH_INT_DIGITS;
                    end
                end

                PH_STR_LEN:
                begin
                    if (pop_word.cls == CLS_COLON)
                    begin
                        if (ovf_reg || (acc_reg >= limit_ext))
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TOO_LONG;
                        end
                        else if (acc_reg == '0)
                        begin
                            emit       = 1'b1;
                            res_kind   = KIND_HEADER;
                            phase_next = PH_IDLE;
                        end
                        else if (pop_word.last)
                        begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            res_kind   = KIND_HEADER;
                            res_len    = acc_reg[LEN_OUT_W-1:0];
                            rem_next   = acc_reg[STRING_LENGTH_BITS-1:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    else if (pop_word.cls != CLS_DIGIT)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_COLON;
                    end
                    else if (pop_word.last)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else if (!ovf_reg)
                    begin
                        acc_next = ACC_W'(str_acc10);
                        ovf_next = (str_acc10 >= STR_ACC_W'(limit_reg));
                    end
                end

                PH_PAYLOAD:
                begin
                    rem_next = rem_dec;
                    if (pop_word.last && (rem_dec != '0))
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        res_kind = KIND_BYTE;
                        res_pb   = pop_word.data;
                        if (rem_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end

                PH_SKIP:
                begin
                    if (pop_word.last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end

                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // error report, then skip to the end of the buffer
            if (fail)
            begin
                emit       = 1'b1;
                res_kind   = KIND_ERROR;
                res_err    = fail_code;
                phase_next = pop_word.last ? PH_IDLE : PH_SKIP;
            end
        end
    end

    // output register occupancy
    always_comb
    begin
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            ovf_reg       <= ovf_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg <= res_kind;
            int_reg  <= res_int;
            len_reg  <= res_len;
            pb_reg   <= res_pb;
            err_reg  <= res_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign int_value     = int_reg;
    assign str_len       = len_reg;
    assign payload_byte  = pb_reg;
    assign error_code    = err_reg;

endmodule

@@ design/bencode_byte_tokenizer_top.sv @@
// bencode byte tokenizer
// input channel: in_valid/in_ready carry one buffer byte per word (data_byte)
// with last_byte set on the final byte of the buffer
// output channel: out_valid/out_ready carry one token word: kind, int_value,
// str_len, payload_byte and error_code; unused fields read zero
// configuration channel: cfg_valid/cfg_ready write the string length limit from
// cfg_data; cfg_ready is always high, write only while no buffer is in flight
// a byte that yields a token passes through the queue and then the output
// register; bytes inside lengths and integers give no token
// throughput: one byte per cycle while the output is not stalled; the state
// machine does a 64-bit multiply by ten and add with its overflow compare
// a four-word queue sits between byte classification and the state machine
// a stalled receiver holds the token in the output register; the queue then
// fills and in_ready drops once four bytes are waiting
// reset: state machine to idle, queue and output empty, limit 2147483647
module bencode_byte_tokenizer_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             data_byte,
    input  logic                                   last_byte,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [2:0]                             kind,
    output logic signed [63:0]                     int_value,
    output logic [bbt_pkg::LEN_OUT_W-1:0]          str_len,
    output logic [7:0]                             payload_byte,
    output logic [2:0]                             error_code,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bbt_pkg::STRING_LENGTH_BITS-1:0] cfg_data
);
    import bbt_pkg::*;

    logic  push_valid;
    logic  push_ready;
    word_t push_word;
    logic  pop_valid;
    logic  pop_ready;
    word_t pop_word;

    // byte classification
    bbt_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // decoupling queue
    bbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    // token state machine and output register
    bbt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_word      (pop_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .int_value     (int_value),
        .str_len       (str_len),
        .payload_byte  (payload_byte),
        .error_code    (error_code)
    );

    // error code present exactly on error tokens
    a_err_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code on a non-error token");

    a_err_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |-> (error_code != ERR_NONE))
        else $error("error token without a code");

    // payload bytes carry no integer or length
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BYTE) |-> (int_value == '0) && (str_len == '0))
        else $error("payload word with stray fields");

    // only integer tokens carry a value
    a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_INT) |-> (int_value == '0))
        else $error("integer value on a non-integer token");

endmodule
